// ----- sv/atdi_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_pkg
// Shared types and codes for the address to dense index table.
// ----------------------------------------------------------------------------
package atdi_pkg;

    localparam int ADDR_W    = 64;
    localparam int NBYTES    = 8;
    localparam int CFG_W     = 4;
    localparam int IDX_OUT_W = 8;
    localparam logic [ADDR_W-1:0] HASH_INIT = 64'd5381;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2,
        ST_CLEARED  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_SWEEP,
        S_IDLE,
        S_HASH,
        S_RED,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_ENT_RD,
        S_ENT_CHK,
        S_INS,
        S_LINK,
        S_RESP
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    hash_step;
        logic    red_step;
        logic    head_rd;
        logic    take_head;
        logic    ent_rd;
        logic    take_next;
        logic    hit;
        logic    ins_entry;
        logic    ins_link;
        logic    sweep_step;
        logic    res_zero;
        logic    out_load;
        status_t out_code;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hash_last;
        logic red_last;
        logic sweep_last;
        logic head_valid;
        logic ent_hit;
        logic next_valid;
        logic full;
    } stat_t;

endpackage

// ----- sv/atdi_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_datapath
// Hash unit, bucket and entry memories, chain pointers and result register.
// ----------------------------------------------------------------------------
module atdi_datapath #(
    parameter int NUM_BUCKETS    = 64,
    parameter int MAX_ENTRIES    = 256,
    parameter int ADDR_BYTES_MAX = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [atdi_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                 s_func,
    input  logic [atdi_pkg::ADDR_W-1:0]          s_address,
    input  atdi_pkg::cmd_t                       cmd,
    output atdi_pkg::stat_t                      stat,
    output logic [atdi_pkg::IDX_OUT_W-1:0]       m_entry_index,
    output logic [1:0]                           m_status
);
    import atdi_pkg::*;

    localparam int RW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CW    = $clog2(MAX_ENTRIES + 1);

    logic [CFG_W-1:0]  addr_bytes_reg;
    logic [CFG_W-1:0]  n_reg;
    logic [CFG_W-1:0]  n_eff;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] hsh_reg;
    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] acc_next;
    logic [2:0]        byte_cnt_reg;
    logic [2:0]        red_cnt_reg;
    logic [RW-1:0]     rem_reg;
    logic [RW-1:0]     rem_next;
    logic [RW-1:0]     sweep_cnt_reg;
    logic [CW-1:0]     count_reg;
    logic [IDX_W-1:0]  cur_reg;
    logic [IDX_W-1:0]  tail_reg;
    logic              have_tail_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [IDX_OUT_W-1:0] out_idx_reg;
    status_t           out_code_reg;

    logic [IDX_W:0]    head_mem [NUM_BUCKETS];
    logic [IDX_W:0]    head_q;
    logic [ADDR_W-1:0] key_mem [MAX_ENTRIES];
    logic [IDX_W:0]    next_mem [MAX_ENTRIES];
    logic [ADDR_W-1:0] key_q;
    logic [IDX_W:0]    next_q;
    logic              key_eq;

    // clamp the byte count to 1..ADDR_BYTES_MAX
    always_comb begin
        if (addr_bytes_reg == '0) begin
            n_eff = CFG_W'(1);
        end else if (addr_bytes_reg > CFG_W'(ADDR_BYTES_MAX)) begin
            n_eff = CFG_W'(ADDR_BYTES_MAX);
        end else begin
            n_eff = addr_bytes_reg;
        end
    end

    // djb2 step: acc * 33 + sign-extended byte
    assign acc_next = (acc_reg << 5) + acc_reg + {{(ADDR_W-8){hsh_reg[7]}}, hsh_reg[7:0]};

    // remainder by NUM_BUCKETS, eight bits a cycle, MSB first
    always_comb begin
        logic [RW:0] t;
        rem_next = rem_reg;
        for (int k = 0; k < 8; k++) begin
            t = {rem_next, acc_reg[ADDR_W-1-k]};
            if (t >= (RW+1)'(NUM_BUCKETS)) begin
                t = t - (RW+1)'(NUM_BUCKETS);
            end
            rem_next = t[RW-1:0];
        end
    end

    always_comb begin
        key_eq = 1'b1;
        for (int i = 0; i < NBYTES; i++) begin
            if ((CFG_W'(i) < n_reg) && (key_q[8*i +: 8] != addr_reg[8*i +: 8])) begin
                key_eq = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_bytes_reg <= CFG_W'(6);
            count_reg      <= '0;
            sweep_cnt_reg  <= '0;
        end else begin
            if (cfg_wr_en) begin
                addr_bytes_reg <= cfg_wr_data;
            end
            if (cmd.load_item && s_func) begin
                count_reg <= '0;
            end else if (cmd.ins_link) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.sweep_step) begin
                sweep_cnt_reg <= stat.sweep_last ? '0 : sweep_cnt_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            addr_reg      <= s_address;
            hsh_reg       <= s_address;
            acc_reg       <= HASH_INIT;
            n_reg         <= n_eff;
            byte_cnt_reg  <= '0;
            red_cnt_reg   <= '0;
            rem_reg       <= '0;
            have_tail_reg <= 1'b0;
        end
        if (cmd.hash_step) begin
            acc_reg      <= acc_next;
            hsh_reg      <= hsh_reg >> 8;
            byte_cnt_reg <= byte_cnt_reg + 3'd1;
        end
        if (cmd.red_step) begin
            acc_reg     <= acc_reg << 8;
            rem_reg     <= rem_next;
            red_cnt_reg <= red_cnt_reg + 3'd1;
        end
        if (cmd.take_head) begin
            cur_reg <= head_q[IDX_W-1:0];
        end
        if (cmd.take_next) begin
            tail_reg      <= cur_reg;
            have_tail_reg <= 1'b1;
            cur_reg       <= next_q[IDX_W-1:0];
        end
        if (cmd.hit) begin
            res_idx_reg <= cur_reg;
        end
        if (cmd.ins_entry) begin
            res_idx_reg <= count_reg[IDX_W-1:0];
        end
        if (cmd.res_zero) begin
            res_idx_reg <= '0;
        end
        if (cmd.out_load) begin
            out_idx_reg  <= IDX_OUT_W'(res_idx_reg);
            out_code_reg <= cmd.out_code;
        end
    end

    // bucket heads: one write port shared by the clearing sweep and the link
    always_ff @(posedge aclk) begin
        if (cmd.sweep_step) begin
            head_mem[sweep_cnt_reg] <= '0;
        end else if (cmd.ins_link && !have_tail_reg) begin
            head_mem[rem_reg] <= {1'b1, count_reg[IDX_W-1:0]};
        end
        if (cmd.head_rd) begin
            head_q <= head_mem[rem_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_entry) begin
            key_mem[count_reg[IDX_W-1:0]] <= addr_reg;
        end
        if (cmd.ent_rd) begin
            key_q <= key_mem[cur_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ins_entry) begin
            next_mem[count_reg[IDX_W-1:0]] <= '0;
        end else if (cmd.ins_link && have_tail_reg) begin
            next_mem[tail_reg] <= {1'b1, count_reg[IDX_W-1:0]};
        end
        if (cmd.ent_rd) begin
            next_q <= next_mem[cur_reg];
        end
    end

    assign stat.hash_last  = (byte_cnt_reg == 3'(n_reg - CFG_W'(1)));
    assign stat.red_last   = (red_cnt_reg == 3'd7);
    assign stat.sweep_last = (sweep_cnt_reg == RW'(NUM_BUCKETS - 1));
    assign stat.head_valid = head_q[IDX_W];
    assign stat.ent_hit    = key_eq;
    assign stat.next_valid = next_q[IDX_W];
    assign stat.full       = (count_reg >= CW'(MAX_ENTRIES));

    assign m_entry_index = out_idx_reg;
    assign m_status      = out_code_reg;

endmodule

// ----- sv/atdi_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atdi_ctrl
// Sequencer for hashing, chain walk, insert, clear sweep and result handoff.
// ----------------------------------------------------------------------------
module atdi_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_func,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    input  atdi_pkg::stat_t  stat,
    output atdi_pkg::cmd_t   cmd
);
    import atdi_pkg::*;

    state_t  state_reg, state_next;
    status_t code_reg, code_next;
    logic    clr_reg, clr_next;
    logic    m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_SWEEP;
            code_reg    <= ST_FOUND;
            clr_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            code_reg    <= code_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        cmd          = '0;
        cmd.out_code = code_reg;
        state_next   = state_reg;
        code_next    = code_reg;
        clr_next     = clr_reg;
        unique case (state_reg)
            S_SWEEP: begin
                cmd.sweep_step = 1'b1;
                cmd.res_zero   = 1'b1;
                if (stat.sweep_last) begin
                    clr_next = 1'b0;
                    if (clr_reg) begin
                        code_next  = ST_CLEARED;
                        state_next = S_RESP;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    if (s_func) begin
                        clr_next   = 1'b1;
                        state_next = S_SWEEP;
                    end else begin
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH: begin
                cmd.hash_step = 1'b1;
                if (stat.hash_last) begin
                    state_next = S_RED;
                end
            end
            S_RED: begin
                cmd.red_step = 1'b1;
                if (stat.red_last) begin
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                cmd.head_rd = 1'b1;
                state_next  = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                if (stat.head_valid) begin
                    cmd.take_head = 1'b1;
                    state_next    = S_ENT_RD;
                end else begin
                    state_next = S_INS;
                end
            end
            S_ENT_RD: begin
                cmd.ent_rd = 1'b1;
                state_next = S_ENT_CHK;
            end
            S_ENT_CHK: begin
                if (stat.ent_hit) begin
                    cmd.hit    = 1'b1;
                    code_next  = ST_FOUND;
                    state_next = S_RESP;
                end else begin
                    cmd.take_next = 1'b1;
                    state_next    = stat.next_valid ? S_ENT_RD : S_INS;
                end
            end
            S_INS: begin
                if (stat.full) begin
                    cmd.res_zero = 1'b1;
                    code_next    = ST_FULL;
                    state_next   = S_RESP;
                end else begin
                    cmd.ins_entry = 1'b1;
                    state_next    = S_LINK;
                end
            end
            S_LINK: begin
                cmd.ins_link = 1'b1;
                code_next    = ST_INSERTED;
                state_next   = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;

`ifndef SYNTHESIS
    a_no_insert_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ins_entry |-> !stat.full)
        else $error("insert issued with table full");
    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");
    a_clear_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_func) |=> (state_reg == S_SWEEP))
        else $error("clear word did not start sweep");
    a_one_mem_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.head_rd, cmd.ent_rd, cmd.ins_entry, cmd.ins_link, cmd.sweep_step}))
        else $error("conflicting memory commands");
`endif

endmodule

// ----- sv/address_to_dense_index_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_to_dense_index_table
// Gives addresses dense indices in order of first sight via a chained hash.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (s_func, s_address) arrive on a valid/ready channel. A lookup
//   word (s_func = 0) hashes the low addr_bytes bytes with djb2 and walks the
//   bucket chain; a hit returns the stored index, a miss appends a new entry
//   numbered with the current count, or reports full when the table is full.
//   A clear word (s_func = 1) empties all buckets and zeroes the count.
//   One result word (m_entry_index, m_status) leaves per input word.
//   A lookup steps through the hash of n bytes (n = clamped addr_bytes), the
//   bucket remainder, the head fetch, a read and compare per chain entry
//   visited, the insert or full check, and the load of the result register.
//   A clear runs the one-bucket-a-cycle sweep of the head memory before its
//   result is loaded. Only one word is in flight; the next is taken once
//   the result sits in the output register.
//   Reset runs the same sweep with s_ready low; cfg_wr_en writes are taken at
//   any time. A stalled receiver holds the result; the block takes one
//   further word and parks its result until the output register frees.
// ----------------------------------------------------------------------------
module address_to_dense_index_table #(
    parameter int NUM_BUCKETS    = 64,
    parameter int MAX_ENTRIES    = 256,
    parameter int ADDR_BYTES_MAX = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [atdi_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [atdi_pkg::ADDR_W-1:0]    s_address,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [atdi_pkg::IDX_OUT_W-1:0] m_entry_index,
    output logic [1:0]                     m_status
);
    import atdi_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // sequencer: owns the handshakes and the result valid flag
    atdi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // datapath: hash, memories, chain pointers and result payload
    atdi_datapath #(
        .NUM_BUCKETS    (NUM_BUCKETS),
        .MAX_ENTRIES    (MAX_ENTRIES),
        .ADDR_BYTES_MAX (ADDR_BYTES_MAX)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_func        (s_func),
        .s_address     (s_address),
        .cmd           (cmd),
        .stat          (stat),
        .m_entry_index (m_entry_index),
        .m_status      (m_status)
    );

endmodule

// ----- verif/tb_address_to_dense_index_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_address_to_dense_index_table
// Self-checking bench for the address to dense index table: drives lookup and
// clear words under random idling, predicts each result word with a behavioral
// copy of the chained hash table, and compares every result in order.
// ----------------------------------------------------------------------------
class index_scoreboard;
    // behavioral table state
    bit        head_ok  [64];
    bit [7:0]  head_idx [64];
    bit [63:0] key      [256];
    bit        next_ok  [256];
    bit [7:0]  next_idx [256];
    int        count;
    bit [3:0]  addr_bytes;
    // expected result words, oldest first
    bit [7:0]  want_index [$];
    atdi_pkg::status_t want_status [$];
    int        errors;

    function void clear_table();
        foreach (head_ok[i]) head_ok[i] = 1'b0;
        count = 0;
    endfunction

    function void reset_state();
        clear_table();
        addr_bytes = 4'd6;
        errors = 0;
    endfunction

    function int bucket_of(bit [63:0] a, int n);
        bit [63:0] acc;
        acc = 64'd5381;
        for (int i = 0; i < n; i++)
            acc = (acc << 5) + acc + {{56{a[8*i+7]}}, a[8*i +: 8]};
        return int'(acc[5:0]);
    endfunction

    // Predict the result of one accepted input word and update the table.
    function void note_word(bit func, bit [63:0] a);
        int n, b, cur, tail, steps;
        bit have_tail, ok;
        bit [63:0] mask;
        if (func) begin
            clear_table();
            want_index.push_back(8'd0);
            want_status.push_back(atdi_pkg::ST_CLEARED);
            return;
        end
        n = (addr_bytes < 1) ? 1 : (addr_bytes > 8) ? 8 : int'(addr_bytes);
        mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
        b = bucket_of(a, n);
        have_tail = 1'b0;
        tail = 0;
        ok = head_ok[b];
        cur = int'(head_idx[b]);
        steps = 0;
        while (ok && steps < 256) begin
            if (((key[cur] ^ a) & mask) == 64'd0) begin
                want_index.push_back(cur[7:0]);
                want_status.push_back(atdi_pkg::ST_FOUND);
                return;
            end
            have_tail = 1'b1;
            tail = cur;
            ok = next_ok[cur];
            cur = int'(next_idx[cur]);
            steps++;
        end
        if (count >= 256) begin
            want_index.push_back(8'd0);
            want_status.push_back(atdi_pkg::ST_FULL);
            return;
        end
        key[count] = a;
        next_ok[count] = 1'b0;
        if (have_tail) begin
            next_ok[tail] = 1'b1;
            next_idx[tail] = count[7:0];
        end else begin
            head_ok[b] = 1'b1;
            head_idx[b] = count[7:0];
        end
        want_index.push_back(count[7:0]);
        want_status.push_back(atdi_pkg::ST_INSERTED);
        count++;
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_word(bit [7:0] idx, bit [1:0] st);
        if (want_index.size() == 0) begin
            report($sformatf("unexpected word index=%0d status=%0d", idx, st));
            return;
        end
        if (idx !== want_index[0])
            report($sformatf("entry_index got %0d want %0d", idx, want_index[0]));
        if (st !== want_status[0])
            report($sformatf("status got %0d want %0d", st, want_status[0]));
        void'(want_index.pop_front());
        void'(want_status.pop_front());
    endtask
endclass

module tb_address_to_dense_index_table;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_func = 1'b0;
    logic [63:0] s_address = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_entry_index;
    logic [1:0]  m_status;

    index_scoreboard table_model;
    int send_idle_pct = 0;   // chance in a hundred the sender skips a cycle
    int recv_stall_pct = 0;  // chance in a hundred the receiver stalls
    bit [63:0] pool [16];    // small address pool so lookups hit often

    address_to_dense_index_table dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_func(s_func), .s_address(s_address),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_entry_index(m_entry_index), .m_status(m_status)
    );

    always #4 aclk = ~aclk;

    // Hard stop well past the slowest correct run.
    initial begin
        #40ms;
        $display("FAIL");
        $finish;
    end

    // Receiver: stall at random, check every accepted result word.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            table_model.check_word(m_entry_index, m_status);
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Present one word, hold it until accepted, then drop valid for a cycle.
    task automatic send_word(bit func, bit [63:0] a);
        while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        s_valid   <= 1'b1;
        s_func    <= func;
        s_address <= a;
        do @(posedge aclk); while (!s_ready);
        table_model.note_word(func, a);
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Wait until every expected word is back, plus a margin for the block.
    task automatic drain();
        while (table_model.want_index.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    // Write addr_bytes while idle.
    task automatic write_bytes(bit [3:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        table_model.addr_bytes = v;
    endtask

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly reuse of pooled addresses, with fresh ones and rare clears.
    task automatic random_words(int num);
        bit [63:0] a;
        for (int i = 0; i < num; i++) begin
            if ($urandom_range(99) < 2) begin
                send_word(1'b1, rand64());
            end else begin
                a = ($urandom_range(99) < 60) ? pool[$urandom_range(15)] : rand64();
                if ($urandom_range(99) < 10) pool[$urandom_range(15)] = a;
                send_word(1'b0, a);
            end
        end
    endtask

    initial begin
        table_model = new();
        table_model.reset_state();
        foreach (pool[i]) pool[i] = rand64();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, hit, miss, clear, byte count edges
        send_word(1'b0, 64'h0);
        send_word(1'b0, '1);
        send_word(1'b0, 64'h0);
        send_word(1'b0, 64'h8080_8080_8080_8080);
        send_word(1'b0, 64'h7F7F_7F7F_7F7F_7F7F);
        send_word(1'b0, 64'hAA00_0000_0000_0000); // upper bytes ignored: hit on 0
        send_word(1'b1, '1);
        send_word(1'b0, '1);
        write_bytes(4'd0);                          // treated as one byte
        send_word(1'b0, 64'h1234_5678_9ABC_DE80);
        send_word(1'b0, 64'h0000_0000_0000_0080);   // hit on low byte only
        write_bytes(4'd15);                         // clamped to eight
        send_word(1'b0, 64'h5555_5555_5555_5555);
        send_word(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
        send_word(1'b0, 64'h1234_5678_9ABC_DE80);   // stored whole, now a full compare

        // fill the table past capacity so full is reported, then clear
        write_bytes(4'd8);
        for (int i = 0; i < 262; i++)
            send_word(1'b0, {$urandom, 16'h0, i[7:0], 8'h11 + i[15:8]});
        send_word(1'b1, 64'd0);

        // random phases under different idling and byte counts
        write_bytes(4'd1);
        random_words(150);
        drain();                                     // sender waits for all results
        send_idle_pct = 88;
        write_bytes(4'd2);
        random_words(150);
        send_idle_pct = 0;
        recv_stall_pct = 88;
        write_bytes(4'd8);
        random_words(200);
        send_idle_pct = 9;
        recv_stall_pct = 9;
        write_bytes(4'd3);
        random_words(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_bytes(4'd6);
        random_words(370);

        drain();
        if (table_model.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
